// File: hdl/barycentric_rational_interpolator_unit_assert.svh
// assertion macros for the interpolator checker
`ifndef BARYCENTRIC_RATIONAL_INTERPOLATOR_UNIT_ASSERT_SVH
`define BARYCENTRIC_RATIONAL_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BRII_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRII_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/brii_pkg.sv
// shared types, codes and constants of the interpolator
package brii_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic CFG_ORDER = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef struct packed {
    logic               neg;
    logic signed [15:0] ex;
    logic [31:0]        mag;
  } xnum_t;

  localparam xnum_t XZERO = '{neg: 1'b0, ex: 16'sd0, mag: 32'd0};
  localparam xnum_t XONE  = '{neg: 1'b0, ex: -16'sd31, mag: 32'h8000_0000};

  typedef enum logic [1:0] {XO_FIX, XO_MUL, XO_DIV, XO_ADD} xop_t;

  typedef enum logic [4:0] {
    CM_NOP, CM_LOAD, CM_LATCH_Q, CM_I_CLR, CM_I_INC, CM_J_INC, CM_RD_I, CM_RD_J,
    CM_DUP_XI, CM_WB_INIT, CM_TERM_INIT, CM_K_INC, CM_WR_W, CM_EV_INIT, CM_EV_LATCH,
    CM_X_FIX_XJ, CM_X_FIX_QX, CM_X_FIX_Y, CM_X_MUL_PROD, CM_X_DIV_ONE, CM_X_ADD_W,
    CM_X_DIV_WT, CM_X_ADD_DEN, CM_X_MUL_TY, CM_X_ADD_NUM, CM_X_DIV_ND,
    CM_RES_ERR, CM_RES_Y, CM_RES_CONV
  } cmd_t;

  typedef struct packed {
    cmd_t       op;
    logic [1:0] code;
  } ctl_cmd_t;

  typedef struct packed {
    logic xdone;
    logic wcur;
    logic bad_order;
    logic n_one;
    logic i_last;
    logic i_dup_last;
    logic j_last;
    logic j_eq_i;
    logic jw_last;
    logic k_last;
    logic x_eq_q;
    logic x_eq_xi;
    logic den_zero;
  } dp_stat_t;

endpackage

// File: hdl/brii_ram.sv
// generic single-write, single-read ram with registered read
module brii_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/brii_xunit.sv
// shared multi-cycle float unit: convert, multiply, divide, add, normalize
module brii_xunit import brii_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  xop_t               op,
  input  xnum_t              a,
  input  xnum_t              b,
  input  logic signed [33:0] v,
  output logic               done,
  output xnum_t              res
);

  typedef enum logic [1:0] {X_IDLE, X_DIV, X_NORM} xst_t;

  xst_t               xst;
  logic [63:0]        m;
  logic [63:0]        dd;
  logic [32:0]        rem;
  logic [31:0]        dv;
  logic signed [15:0] e;
  logic               neg;
  logic [5:0]         cnt;

  xnum_t       big, sml;
  logic [16:0] dif;
  logic [63:0] aa, bb0, bb, sum;
  logic        sneg, same, ge;
  logic [32:0] rem_sh;
  logic        q_bit;
  logic [33:0] vabs;

  always_comb begin
    if (a.ex >= b.ex) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    dif  = {big.ex[15], big.ex} - {sml.ex[15], sml.ex};
    aa   = {1'b0, big.mag, 31'd0};
    bb0  = {1'b0, sml.mag, 31'd0};
    bb   = (dif >= 17'd63) ? 64'd0 : (bb0 >> dif[5:0]);
    same = (big.neg == sml.neg);
    ge   = (aa >= bb);
    if (same) begin
      sum  = aa + bb;
      sneg = big.neg;
    end else if (ge) begin
      sum  = aa - bb;
      sneg = big.neg;
    end else begin
      sum  = bb - aa;
      sneg = sml.neg;
    end
    rem_sh = {rem[31:0], dd[63]};
    q_bit  = (rem_sh >= {1'b0, dv});
    vabs   = v[33] ? (34'd0 - v) : v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xst  <= X_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (xst)
        X_IDLE: begin
          if (start) begin
            case (op)
              XO_FIX: begin
                m   <= {30'd0, vabs};
                e   <= -16'(FRAC_BITS);
                neg <= v[33];
                xst <= X_NORM;
              end
              XO_MUL: begin
                m   <= 64'(a.mag) * 64'(b.mag);
                e   <= a.ex + b.ex;
                neg <= a.neg ^ b.neg;
                xst <= X_NORM;
              end
              XO_DIV: begin
                m   <= 64'd0;
                neg <= a.neg ^ b.neg;
                e   <= a.ex - 16'sd32 - b.ex;
                dd  <= {a.mag, 32'd0};
                dv  <= b.mag;
                rem <= 33'd0;
                cnt <= 6'd63;
                if (a.mag == 32'd0 || b.mag == 32'd0) begin
                  xst <= X_NORM;
                end else begin
                  xst <= X_DIV;
                end
              end
              XO_ADD: begin
                if (a.mag == 32'd0) begin
                  res  <= b;
                  done <= 1'b1;
                end else if (b.mag == 32'd0) begin
                  res  <= a;
                  done <= 1'b1;
                end else begin
                  m   <= sum;
                  e   <= big.ex - 16'sd31;
                  neg <= sneg;
                  xst <= X_NORM;
                end
              end
              default: xst <= X_IDLE;
            endcase
          end
        end
        X_DIV: begin
          rem <= q_bit ? (rem_sh - {1'b0, dv}) : rem_sh;
          dd  <= {dd[62:0], 1'b0};
          m   <= {m[62:0], q_bit};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            xst <= X_NORM;
          end
        end
        X_NORM: begin
          if (m == 64'd0) begin
            res  <= XZERO;
            done <= 1'b1;
            xst  <= X_IDLE;
          end else if (m[63]) begin
            res  <= '{neg: neg, ex: e + 16'sd32, mag: m[63:32]};
            done <= 1'b1;
            xst  <= X_IDLE;
          end else if (m[63:56] == 8'd0) begin
            m <= {m[55:0], 8'd0};
            e <= e - 16'sd8;
          end else begin
            m <= {m[62:0], 1'b0};
            e <= e - 16'sd1;
          end
        end
        default: xst <= X_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/brii_dpath.sv
// datapath: node stores, counters, accumulators, float unit, result conversion
module brii_dpath import brii_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  ctl_cmd_t     cmd,
  output dp_stat_t     stat,
  input  logic [5:0]   node_index,
  input  logic [31:0]  point_x,
  input  logic [31:0]  point_y,
  input  logic         cfg_valid,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_data,
  output logic         done,
  output logic [31:0]  approx_value,
  output logic [1:0]   status
);

  localparam int NB = $clog2(MAX_NODES + 1);
  localparam int CW = (NB > 7) ? NB + 1 : 8;
  localparam int AW = $clog2(MAX_NODES);
  localparam int XW = $bits(xnum_t);

  logic [5:0]    order;
  logic [6:0]    count;
  logic          wcur;
  logic [CW-1:0] i, j, k;
  logic [31:0]   q, xi, ybuf;
  xnum_t         wbuf, prod, w, t, tmp, num, den;
  cmd_t          dest;

  logic [CW-1:0] n_eff, nc_ext, d_ext, nm1, lim, klo, khi, widx;
  logic [31:0]   xrd, yrd;
  logic [XW-1:0] wrd;
  logic [AW-1:0] raddr;
  logic          ld_we, ld_ok;

  logic               xstart, xdone;
  xop_t               xop;
  xnum_t              xa, xb, xres;
  logic signed [33:0] xv;

  logic signed [16:0] s;
  logic [6:0]         nsh;
  logic [32:0]        r;
  logic [31:0]        cv_val;
  logic [1:0]         cv_st;

  always_comb begin
    nc_ext = {{(CW-7){1'b0}}, count};
    d_ext  = {{(CW-6){1'b0}}, order};
    n_eff  = (nc_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_ext;
    nm1    = n_eff - CW'(1);
    lim    = nm1 - d_ext;
    klo    = (i >= d_ext) ? (i - d_ext) : '0;
    khi    = (i < lim) ? i : lim;
    widx   = {{(CW-6){1'b0}}, node_index};
    ld_ok  = (widx < CW'(MAX_NODES));
    ld_we  = (cmd.op == CM_LOAD) && ld_ok;
    raddr  = (cmd.op == CM_RD_J) ? j[AW-1:0] : i[AW-1:0];

    stat.xdone      = xdone;
    stat.wcur       = wcur;
    stat.bad_order  = (n_eff == '0) || (d_ext >= n_eff);
    stat.n_one      = (n_eff == CW'(1));
    stat.i_last     = (i == nm1);
    stat.i_dup_last = (i == n_eff - CW'(2));
    stat.j_last     = (j == nm1);
    stat.j_eq_i     = (j == i);
    stat.jw_last    = (j == k + d_ext);
    stat.k_last     = (k == khi);
    stat.x_eq_q     = (xrd == q);
    stat.x_eq_xi    = (xrd == xi);
    stat.den_zero   = (den.mag == 32'd0);
  end

  brii_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_xram (
    .clk(clk), .we(ld_we), .waddr(widx[AW-1:0]), .wdata(point_x),
    .raddr(raddr), .rdata(xrd)
  );

  brii_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_yram (
    .clk(clk), .we(ld_we), .waddr(widx[AW-1:0]), .wdata(point_y),
    .raddr(raddr), .rdata(yrd)
  );

  brii_ram #(.WIDTH(XW), .DEPTH(MAX_NODES)) u_wram (
    .clk(clk), .we(cmd.op == CM_WR_W), .waddr(i[AW-1:0]), .wdata(w),
    .raddr(raddr), .rdata(wrd)
  );

  always_comb begin
    xstart = 1'b1;
    xop    = XO_ADD;
    xa     = XZERO;
    xb     = XZERO;
    xv     = '0;
    case (cmd.op)
      CM_X_FIX_XJ: begin
        xop = XO_FIX;
        xv  = {{2{xi[31]}}, xi} - {{2{xrd[31]}}, xrd};
      end
      CM_X_FIX_QX: begin
        xop = XO_FIX;
        xv  = {{2{q[31]}}, q} - {{2{xi[31]}}, xi};
      end
      CM_X_FIX_Y: begin
        xop = XO_FIX;
        xv  = {{2{ybuf[31]}}, ybuf};
      end
      CM_X_MUL_PROD: begin
        xop = XO_MUL;
        xa  = prod;
        xb  = tmp;
      end
      CM_X_DIV_ONE: begin
        xop = XO_DIV;
        xa  = XONE;
        xb  = prod;
      end
      CM_X_ADD_W: begin
        xa     = w;
        xb     = tmp;
        xb.neg = tmp.neg ^ k[0];
      end
      CM_X_DIV_WT: begin
        xop = XO_DIV;
        xa  = wbuf;
        xb  = tmp;
      end
      CM_X_ADD_DEN: begin
        xa = den;
        xb = t;
      end
      CM_X_MUL_TY: begin
        xop = XO_MUL;
        xa  = t;
        xb  = tmp;
      end
      CM_X_ADD_NUM: begin
        xa = num;
        xb = tmp;
      end
      CM_X_DIV_ND: begin
        xop = XO_DIV;
        xa  = num;
        xb  = den;
      end
      default: xstart = 1'b0;
    endcase
  end

  brii_xunit #(.FRAC_BITS(FRAC_BITS)) u_xunit (
    .clk(clk), .rst(rst), .start(xstart), .op(xop), .a(xa), .b(xb), .v(xv),
    .done(xdone), .res(xres)
  );

  // fixed-point conversion of the final quotient
  always_comb begin
    s   = {tmp.ex[15], tmp.ex} + 17'(FRAC_BITS);
    nsh = 7'(17'sd0 - s);
    if (tmp.mag == 32'd0) begin
      r = 33'd0;
    end else if (s > 17'sd0) begin
      r = 33'h1_0000_0000;
    end else if (s > -17'sd64) begin
      r = {1'b0, tmp.mag} >> nsh[5:0];
    end else begin
      r = 33'd0;
    end
    cv_st = ST_OK;
    if (!tmp.neg && r > 33'h0_7FFF_FFFF) begin
      cv_val = 32'h7FFF_FFFF;
      cv_st  = ST_SAT;
    end else if (tmp.neg && r > 33'h0_8000_0000) begin
      cv_val = 32'h8000_0000;
      cv_st  = ST_SAT;
    end else begin
      cv_val = tmp.neg ? (32'd0 - r[31:0]) : r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= 6'd0;
      count <= 7'd1;
      wcur  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) begin
        wcur <= 1'b0;
        if (cfg_index == CFG_ORDER) begin
          order <= cfg_data[5:0];
        end else begin
          count <= cfg_data;
        end
      end
      if (ld_we) begin
        wcur <= 1'b0;
      end
      if (cmd.op == CM_EV_INIT) begin
        wcur <= 1'b1;
      end
      if (cmd.op == CM_RES_ERR || cmd.op == CM_RES_Y || cmd.op == CM_RES_CONV) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CM_LATCH_Q: q <= point_x;
      CM_I_CLR:   i <= '0;
      CM_I_INC:   i <= i + CW'(1);
      CM_J_INC:   j <= j + CW'(1);
      CM_DUP_XI: begin
        xi <= xrd;
        j  <= i + CW'(1);
      end
      CM_WB_INIT: begin
        xi <= xrd;
        w  <= XZERO;
        k  <= klo;
      end
      CM_TERM_INIT: begin
        prod <= XONE;
        j    <= k;
      end
      CM_K_INC: k <= k + CW'(1);
      CM_EV_INIT: begin
        i   <= '0;
        num <= XZERO;
        den <= XZERO;
      end
      CM_EV_LATCH: begin
        xi   <= xrd;
        ybuf <= yrd;
        wbuf <= xnum_t'(wrd);
      end
      CM_RES_ERR: begin
        approx_value <= 32'd0;
        status       <= cmd.code;
      end
      CM_RES_Y: begin
        approx_value <= yrd;
        status       <= ST_OK;
      end
      CM_RES_CONV: begin
        approx_value <= cv_val;
        status       <= cv_st;
      end
      default: ;
    endcase
    if (xstart) begin
      dest <= cmd.op;
    end
    if (xdone) begin
      case (dest)
        CM_X_MUL_PROD: prod <= xres;
        CM_X_ADD_W:    w    <= xres;
        CM_X_DIV_WT:   t    <= xres;
        CM_X_ADD_DEN:  den  <= xres;
        CM_X_ADD_NUM:  num  <= xres;
        default:       tmp  <= xres;
      endcase
    end
  end

endmodule

// File: hdl/brii_ctrl.sv
// controller state machine sequencing the datapath
module brii_ctrl import brii_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     func,
  input  dp_stat_t stat,
  output logic     busy,
  output ctl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_CHECK, S_DUP_RDI, S_DUP_LXI, S_DUP_RDJ, S_DUP_CMP, S_MAT_RD, S_MAT_CMP,
    S_WB_RDI, S_WB_LXI, S_WB_TERM, S_WB_JCHK, S_WB_FIX, S_WB_MUL, S_WB_MULD, S_WB_DIV,
    S_WB_ADD, S_WB_ADDD, S_WB_WR, S_WB_NEXT, S_EV_RD, S_EV_LATCH, S_EV_FIX, S_EV_DIV,
    S_EV_DEN, S_EV_FY, S_EV_MUL, S_EV_NUM, S_EV_NEXT, S_FIN, S_FOUT, S_XWAIT
  } state_t;

  state_t state, state_next, ret, ret_next;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = CM_NOP;
    cmd.code   = ST_OK;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          if (func) begin
            cmd.op     = CM_LATCH_Q;
            state_next = S_CHECK;
          end else begin
            cmd.op = CM_LOAD;
          end
        end
      end
      S_CHECK: begin
        if (stat.bad_order) begin
          cmd.op     = CM_RES_ERR;
          cmd.code   = ST_ORDER;
          state_next = S_IDLE;
        end else begin
          cmd.op     = CM_I_CLR;
          state_next = stat.n_one ? S_MAT_RD : S_DUP_RDI;
        end
      end
      S_DUP_RDI: begin
        cmd.op     = CM_RD_I;
        state_next = S_DUP_LXI;
      end
      S_DUP_LXI: begin
        cmd.op     = CM_DUP_XI;
        state_next = S_DUP_RDJ;
      end
      S_DUP_RDJ: begin
        cmd.op     = CM_RD_J;
        state_next = S_DUP_CMP;
      end
      S_DUP_CMP: begin
        if (stat.x_eq_xi) begin
          cmd.op     = CM_RES_ERR;
          cmd.code   = ST_DUP;
          state_next = S_IDLE;
        end else if (!stat.j_last) begin
          cmd.op     = CM_J_INC;
          state_next = S_DUP_RDJ;
        end else if (stat.i_dup_last) begin
          cmd.op     = CM_I_CLR;
          state_next = S_MAT_RD;
        end else begin
          cmd.op     = CM_I_INC;
          state_next = S_DUP_RDI;
        end
      end
      S_MAT_RD: begin
        cmd.op     = CM_RD_I;
        state_next = S_MAT_CMP;
      end
      S_MAT_CMP: begin
        if (stat.x_eq_q) begin
          cmd.op     = CM_RES_Y;
          state_next = S_IDLE;
        end else if (!stat.i_last) begin
          cmd.op     = CM_I_INC;
          state_next = S_MAT_RD;
        end else if (stat.wcur) begin
          cmd.op     = CM_EV_INIT;
          state_next = S_EV_RD;
        end else begin
          cmd.op     = CM_I_CLR;
          state_next = S_WB_RDI;
        end
      end
      S_WB_RDI: begin
        cmd.op     = CM_RD_I;
        state_next = S_WB_LXI;
      end
      S_WB_LXI: begin
        cmd.op     = CM_WB_INIT;
        state_next = S_WB_TERM;
      end
      S_WB_TERM: begin
        cmd.op     = CM_TERM_INIT;
        state_next = S_WB_JCHK;
      end
      S_WB_JCHK: begin
        if (!stat.j_eq_i) begin
          cmd.op     = CM_RD_J;
          state_next = S_WB_FIX;
        end else if (stat.jw_last) begin
          state_next = S_WB_DIV;
        end else begin
          cmd.op = CM_J_INC;
        end
      end
      S_WB_FIX: begin
        cmd.op     = CM_X_FIX_XJ;
        ret_next   = S_WB_MUL;
        state_next = S_XWAIT;
      end
      S_WB_MUL: begin
        cmd.op     = CM_X_MUL_PROD;
        ret_next   = S_WB_MULD;
        state_next = S_XWAIT;
      end
      S_WB_MULD: begin
        if (stat.jw_last) begin
          state_next = S_WB_DIV;
        end else begin
          cmd.op     = CM_J_INC;
          state_next = S_WB_JCHK;
        end
      end
      S_WB_DIV: begin
        cmd.op     = CM_X_DIV_ONE;
        ret_next   = S_WB_ADD;
        state_next = S_XWAIT;
      end
      S_WB_ADD: begin
        cmd.op     = CM_X_ADD_W;
        ret_next   = S_WB_ADDD;
        state_next = S_XWAIT;
      end
      S_WB_ADDD: begin
        if (stat.k_last) begin
          state_next = S_WB_WR;
        end else begin
          cmd.op     = CM_K_INC;
          state_next = S_WB_TERM;
        end
      end
      S_WB_WR: begin
        cmd.op     = CM_WR_W;
        state_next = S_WB_NEXT;
      end
      S_WB_NEXT: begin
        if (stat.i_last) begin
          cmd.op     = CM_EV_INIT;
          state_next = S_EV_RD;
        end else begin
          cmd.op     = CM_I_INC;
          state_next = S_WB_RDI;
        end
      end
      S_EV_RD: begin
        cmd.op     = CM_RD_I;
        state_next = S_EV_LATCH;
      end
      S_EV_LATCH: begin
        cmd.op     = CM_EV_LATCH;
        state_next = S_EV_FIX;
      end
      S_EV_FIX: begin
        cmd.op     = CM_X_FIX_QX;
        ret_next   = S_EV_DIV;
        state_next = S_XWAIT;
      end
      S_EV_DIV: begin
        cmd.op     = CM_X_DIV_WT;
        ret_next   = S_EV_DEN;
        state_next = S_XWAIT;
      end
      S_EV_DEN: begin
        cmd.op     = CM_X_ADD_DEN;
        ret_next   = S_EV_FY;
        state_next = S_XWAIT;
      end
      S_EV_FY: begin
        cmd.op     = CM_X_FIX_Y;
        ret_next   = S_EV_MUL;
        state_next = S_XWAIT;
      end
      S_EV_MUL: begin
        cmd.op     = CM_X_MUL_TY;
        ret_next   = S_EV_NUM;
        state_next = S_XWAIT;
      end
      S_EV_NUM: begin
        cmd.op     = CM_X_ADD_NUM;
        ret_next   = S_EV_NEXT;
        state_next = S_XWAIT;
      end
      S_EV_NEXT: begin
        if (stat.i_last) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = CM_I_INC;
          state_next = S_EV_RD;
        end
      end
      S_FIN: begin
        if (stat.den_zero) begin
          cmd.op     = CM_RES_ERR;
          cmd.code   = ST_SAT;
          state_next = S_IDLE;
        end else begin
          cmd.op     = CM_X_DIV_ND;
          ret_next   = S_FOUT;
          state_next = S_XWAIT;
        end
      end
      S_FOUT: begin
        cmd.op     = CM_RES_CONV;
        state_next = S_IDLE;
      end
      S_XWAIT: begin
        if (stat.xdone) begin
          state_next = ret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// File: hdl/barycentric_rational_interpolator_unit.sv
// top level of the barycentric rational interpolator
// A load item (func 0) writes one node and gives no result.
// An evaluate item (func 1) returns one result on done, held for one cycle
// only; the receiver cannot stall it. An evaluate runs a duplicate scan over
// the node pairs and, when the weights are stale after a load or register
// write, rebuilds them from the product terms of each window, their
// reciprocals and their accumulation, before the weighted sum over the nodes.
// All float work runs through the one shared float unit, whose divider
// retires one quotient bit per cycle.
module barycentric_rational_interpolator_unit import brii_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [5:0]  node_index,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  output logic        done,
  output logic [31:0] approx_value,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  brii_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(func), .stat(stat),
    .busy(busy), .cmd(cmd)
  );

  brii_dpath #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .node_index(node_index), .point_x(point_x), .point_y(point_y),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .approx_value(approx_value), .status(status)
  );

endmodule

// File: hdl/brii_checker.sv
// port-level checker for the interpolator, bound to the top level
`include "barycentric_rational_interpolator_unit_assert.svh"

module brii_checker import brii_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        func,
  input logic        done,
  input logic [31:0] approx_value,
  input logic [1:0]  status
);

  `BRII_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
  `BRII_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `BRII_ASSERT_NXT(a_load_silent, start && !busy && !func, !done && !busy, "load item gave a result")
  `BRII_ASSERT_NXT(a_eval_busy, start && !busy && func, busy, "evaluate item not taken")
  `BRII_ASSERT_NOW(a_err_zero, done && (status == ST_ORDER || status == ST_DUP), approx_value == 32'd0, "error result not zero")

endmodule

bind barycentric_rational_interpolator_unit brii_checker u_brii_checker (.*);

// File: verif/barycentric_rational_interpolator_unit_test.sv
// self-checking testbench of the barycentric rational interpolator with a bit-exact predictor
module barycentric_rational_interpolator_unit_test import brii_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FN_LOAD = 1'b0;
  localparam logic FN_EVAL = 1'b1;
  localparam int SLOTS = 64;
  localparam int FRAC = 16;

  typedef struct {
    logic        fn;
    logic [5:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
  } item_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } interp_result_t;

  typedef struct {
    logic [31:0] mag;
    int          ex;
    bit          neg;
  } fnum_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        func = 1'b0;
  logic [5:0]  node_index = '0;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic        done;
  logic [31:0] approx_value;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;

  barycentric_rational_interpolator_unit uut (.*);

  always #4 clk = ~clk;

  item_t          pending_items[$];
  interp_result_t expected_results[$];
  item_t          nxt;
  int             idle_pct = 0;
  int             errors = 0;
  int             n_loads = 0, n_evals = 0;
  int             st_count[4] = '{0, 0, 0, 0};

  // predictor state
  logic [31:0] node_x[SLOTS];
  logic [31:0] node_y[SLOTS];
  fnum_t       node_w[SLOTS];
  bit          weights_ok = 0;
  int          cur_order = 0;
  int          cur_count = 1;
  // stimulus-side copy of the node abscissae
  logic [31:0] gen_x[SLOTS];

  function automatic void add_pending(item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void add_expected(interp_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic fnum_t fnorm(logic [63:0] m, int e, bit ng);
    fnum_t r;
    r.mag = 0; r.ex = 0; r.neg = 0;
    if (m == 0) return r;
    while (!m[63]) begin
      m = m << 1;
      e--;
    end
    r.mag = m[63:32];
    r.ex = e + 32;
    r.neg = ng;
    return r;
  endfunction

  function automatic fnum_t ffix(longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return fnorm(m, -FRAC, v < 0);
  endfunction

  function automatic fnum_t fmul(fnum_t a, fnum_t b);
    return fnorm({32'b0, a.mag} * {32'b0, b.mag}, a.ex + b.ex, a.neg != b.neg);
  endfunction

  function automatic fnum_t fdiv(fnum_t a, fnum_t b);
    if (a.mag == 0 || b.mag == 0) return fnorm(0, 0, 0);
    return fnorm({a.mag, 32'b0} / {32'b0, b.mag}, a.ex - 32 - b.ex, a.neg != b.neg);
  endfunction

  function automatic fnum_t fadd(fnum_t a, fnum_t b);
    fnum_t big, lit;
    logic [63:0] sa, sb, sum;
    longint sh;
    bit ng;
    if (a.mag == 0) return b;
    if (b.mag == 0) return a;
    if (a.ex >= b.ex) begin
      big = a; lit = b;
    end else begin
      big = b; lit = a;
    end
    sa = {32'b0, big.mag} << 31;
    sb = {32'b0, lit.mag} << 31;
    sh = longint'(big.ex) - longint'(lit.ex);
    sb = (sh >= 63) ? 64'd0 : (sb >> sh);
    if (big.neg == lit.neg) begin
      sum = sa + sb; ng = big.neg;
    end else if (sa >= sb) begin
      sum = sa - sb; ng = big.neg;
    end else begin
      sum = sb - sa; ng = lit.neg;
    end
    return fnorm(sum, big.ex - 31, ng);
  endfunction

  function automatic void build_weights(int n, int d);
    fnum_t one, w, prod, t;
    longint xi;
    int klo, khi;
    one = fnorm(1, 0, 0);
    for (int i = 0; i < n; i++) begin
      w = fnorm(0, 0, 0);
      xi = longint'($signed(node_x[i]));
      klo = (i >= d) ? i - d : 0;
      khi = (i < n - 1 - d) ? i : n - 1 - d;
      for (int k = klo; k <= khi; k++) begin
        prod = one;
        for (int j = k; j <= k + d; j++)
          if (j != i) prod = fmul(prod, ffix(xi - longint'($signed(node_x[j]))));
        t = fdiv(one, prod);
        if (k % 2) t.neg = !t.neg;
        w = fadd(w, t);
      end
      node_w[i] = w;
    end
  endfunction

  function automatic interp_result_t interpolate_at(logic [31:0] qraw);
    interp_result_t r;
    int n, d, s;
    longint q;
    fnum_t num, den, t, res;
    logic [63:0] mg;
    n = (cur_count > SLOTS) ? SLOTS : cur_count;
    d = cur_order;
    q = longint'($signed(qraw));
    r.value = '0;
    r.status = ST_OK;
    if (n == 0 || d >= n) begin
      r.status = ST_ORDER;
      return r;
    end
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (node_x[i] == node_x[j]) begin
          r.status = ST_DUP;
          return r;
        end
    for (int i = 0; i < n; i++)
      if (node_x[i] == qraw) begin
        r.value = node_y[i];
        return r;
      end
    if (!weights_ok) begin
      build_weights(n, d);
      weights_ok = 1;
    end
    num = fnorm(0, 0, 0);
    den = num;
    for (int i = 0; i < n; i++) begin
      t = fdiv(node_w[i], ffix(q - longint'($signed(node_x[i]))));
      den = fadd(den, t);
      num = fadd(num, fmul(t, ffix(longint'($signed(node_y[i])))));
    end
    if (den.mag == 0) begin
      r.status = ST_SAT;
      return r;
    end
    res = fdiv(num, den);
    s = res.ex + FRAC;
    if (res.mag == 0) mg = 0;
    else if (s > 0) mg = 64'h1_0000_0000;
    else if (s > -64) mg = {32'b0, res.mag} >> (-s);
    else mg = 0;
    if (!res.neg && mg > 64'h7FFF_FFFF) begin
      r.value = 32'h7FFF_FFFF; r.status = ST_SAT;
    end else if (res.neg && mg > 64'h8000_0000) begin
      r.value = 32'h8000_0000; r.status = ST_SAT;
    end else begin
      r.value = res.neg ? -mg[31:0] : mg[31:0];
    end
    return r;
  endfunction

  function automatic void accept_item(item_t it);
    interp_result_t r;
    if (it.fn == FN_LOAD) begin
      node_x[it.idx] = it.x;
      node_y[it.idx] = it.y;
      weights_ok = 0;
      n_loads++;
    end else begin
      r = interpolate_at(it.x);
      add_expected(r);
      st_count[r.status]++;
      n_evals++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) accept_item('{func, node_index, point_x, point_y});
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_items.pop_front();
          start <= 1'b1;
          func <= nxt.fn;
          node_index <= nxt.idx;
          point_x <= nxt.x;
          point_y <= nxt.y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d", $time, approx_value, status);
        errors++;
      end else begin
        if (approx_value !== expected_results[0].value) begin
          $display("%0t: approx_value expected %h actual %h", $time,
                   expected_results[0].value, approx_value);
          errors++;
        end
        if (status !== expected_results[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   expected_results[0].status, status);
          errors++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  task automatic push_load(int idx, logic [31:0] x, logic [31:0] y);
    add_pending('{FN_LOAD, 6'(idx), x, y});
    gen_x[idx] = x;
  endtask

  task automatic push_eval(logic [31:0] q);
    add_pending('{FN_EVAL, 6'($urandom), q, $urandom});
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || start || busy || expected_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_index <= idx;
    cfg_data <= 7'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_ORDER) cur_order = val & 63;
    else cur_count = val & 127;
    weights_ok = 0;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int d, int n);
    drain();
    write_reg(CFG_ORDER, d);
    write_reg(CFG_COUNT, n);
  endtask

  function automatic logic [31:0] rand_abscissa();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom;
    if (sel == 1) return gen_x[$urandom_range(SLOTS - 1)];
    return 32'($signed($urandom_range(2 * 8 * 65536)) - 8 * 65536);
  endfunction

  function automatic logic [31:0] rand_query(int n);
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return gen_x[$urandom_range(n - 1)];
    if (sel < 7) return gen_x[$urandom_range(n - 1)] + 32'($urandom_range(131072) - 65536);
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_ordinate();
    return ($urandom_range(3) == 0) ? $urandom
                                    : 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
  endfunction

  int n_sel, d_sel;
  logic [31:0] keep_x;

  initial begin
    for (int i = 0; i < SLOTS; i++) gen_x[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill every slot with distinct abscissae
    for (int i = 0; i < SLOTS - 2; i++)
      push_load(i, 32'((i - 32) * 65536 + i * 37), $urandom);
    push_load(62, 32'h8000_0000, 32'h7FFF_FFFF);
    push_load(63, 32'h7FFF_FFFF, 32'h8000_0000);
    push_eval(32'h0001_2345);

    // directed part
    set_regs(0, 64);
    push_eval(32'h8000_0000);
    push_eval(32'h7FFF_FFFF);
    push_eval(32'h0000_8000);
    set_regs(0, 127);
    push_eval(32'hFFF0_0001);
    set_regs(63, 10);
    push_eval(32'h0);
    set_regs(0, 0);
    push_eval(32'h0);
    set_regs(1, 4);
    push_eval(gen_x[0]);
    push_eval(gen_x[3]);
    push_eval(gen_x[1] + 32'h0000_4000);
    push_eval(32'h8000_0000);
    push_eval(32'h7FFF_FFFF);
    keep_x = gen_x[1];
    push_load(1, gen_x[0], 32'h1234_5678);
    push_eval(32'h0000_0100);
    push_load(1, keep_x, 32'h7FFF_FFFF);
    push_load(2, gen_x[2], 32'h8000_0000);
    push_eval(gen_x[1] + 32'h0000_8000);
    set_regs(4, 4);
    push_eval(32'h0);
    set_regs(2, 4);
    push_eval(gen_x[2] - 32'h0000_2000);

    // random part in three idling modes
    for (int mode = 0; mode < 3; mode++) begin
      for (int s = 0; s < 4; s++) begin
        n_sel = $urandom_range(2, 6);
        d_sel = ($urandom_range(7) == 0) ? n_sel : $urandom_range(0, (n_sel > 3) ? 2 : n_sel - 1);
        set_regs(d_sel, n_sel);
        idle_pct = (mode == 0) ? 13 : (mode == 1) ? 82 : 0;
        for (int k = 0; k < 13; k++) begin
          if (mode == 0 && k == 10) drain();
          if ($urandom_range(99) < 35)
            push_load(($urandom_range(4) == 0) ? $urandom_range(SLOTS - 1)
                                                : $urandom_range(n_sel - 1),
                      rand_abscissa(), rand_ordinate());
          else
            push_eval(rand_query(n_sel));
        end
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d loads and %0d evaluations", n_loads, n_evals);
    $display("status mix ok %0d, bad order %0d, duplicates %0d, saturated %0d",
             st_count[0], st_count[1], st_count[2], st_count[3]);
    if (errors == 0) begin
      $display("** barycentric_rational_interpolator_unit: PASSED **");
    end else begin
      $display("** barycentric_rational_interpolator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("** barycentric_rational_interpolator_unit: FAILED **");
    $finish;
  end

endmodule
